// ----- rtl/core/idmt_pkg.sv -----
// Shared types, constants and table-building functions for the IDMT trip-time block.
// Used by idmt_interp, idmt_div and idmt_trip_time; depends on nothing else.
`timescale 1ns / 1ps

package idmt_pkg;

  localparam int X_W      = 24;             // current multiple width
  localparam int TMS_W    = 16;             // time multiplier width
  localparam int CURVE_W  = 4;
  localparam int CFG_W    = 16;
  localparam int T_W      = 32;             // trip time width
  localparam int K_W      = 27;             // curve constant, Q20
  localparam int B_W      = 20;             // IEEE adder constant, Q20
  localparam int NUM_W    = TMS_W + K_W;    // TMS * K
  localparam int BT_W     = TMS_W + B_W - 16;
  localparam int DEF_W    = TMS_W + 4;
  localparam int DEN_W    = 48;
  localparam int SH_W     = 6;
  localparam int E_W      = 5;
  localparam int REM_W    = DEN_W + 33;
  localparam int QUO_BITS = 32;
  localparam int DIV_LAT  = QUO_BITS + 1;
  localparam int INTERP_LAT = 4;
  localparam int SIDE_LEN = 2 * INTERP_LAT + 2;
  localparam int C_W      = 27;

  localparam logic [C_W-1:0] C_0P02_Q32 = C_W'(85899346);
  localparam logic [63:0] Q30_ONE = 64'h0000_0000_4000_0000;

  localparam int DEF_LOG_TABLE_ENTRIES  = 64;
  localparam int DEF_MULTIPLE_FRAC_BITS = 16;

  localparam logic [CURVE_W-1:0] CURVE_RESET = 4'd0;
  localparam logic [TMS_W-1:0]   TMS_RESET   = 16'd4096;

  localparam logic [CURVE_W-1:0] CURVE_IEC_SI   = 4'd0;
  localparam logic [CURVE_W-1:0] CURVE_IEC_VI   = 4'd1;
  localparam logic [CURVE_W-1:0] CURVE_IEC_EI   = 4'd2;
  localparam logic [CURVE_W-1:0] CURVE_IEC_LTI  = 4'd3;
  localparam logic [CURVE_W-1:0] CURVE_IEEE_MI  = 4'd4;
  localparam logic [CURVE_W-1:0] CURVE_IEEE_VI  = 4'd5;
  localparam logic [CURVE_W-1:0] CURVE_IEEE_EI  = 4'd6;
  localparam logic [CURVE_W-1:0] CURVE_DEFINITE = 4'd7;
  localparam logic [CURVE_W-1:0] CURVE_INST     = 4'd8;

  localparam logic CFG_CURVE_SELECT    = 1'b0;
  localparam logic CFG_TIME_MULTIPLIER = 1'b1;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_DEF,
    KIND_LIN,
    KIND_SQ,
    KIND_POW
  } kind_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic               no_trip;
    logic [NUM_W-1:0]   num;
    logic [BT_W-1:0]    bterm;
    logic [DEN_W-1:0]   dsimp;
    logic [SH_W-1:0]    sh;
    logic [E_W-1:0]     e;
    logic [29:0]        pos;
    logic [DEF_W-1:0]   defval;
  } side_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic               no_trip;
    logic [BT_W-1:0]    bterm;
    logic [DEF_W-1:0]   defval;
  } fin_t;

  function automatic logic [K_W-1:0] k_coef(input logic [CURVE_W-1:0] c);
    logic [K_W-1:0] k;
    case (c)
      CURVE_IEC_SI:  k = K_W'(146801);
      CURVE_IEC_VI:  k = K_W'(14155776);
      CURVE_IEC_EI:  k = K_W'(83886080);
      CURVE_IEC_LTI: k = K_W'(125829120);
      CURVE_IEEE_MI: k = K_W'(54002);
      CURVE_IEEE_VI: k = K_W'(20562575);
      CURVE_IEEE_EI: k = K_W'(29569843);
      default:       k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [B_W-1:0] b_coef(input logic [CURVE_W-1:0] c);
    logic [B_W-1:0] b;
    case (c)
      CURVE_IEEE_MI: b = B_W'(119538);
      CURVE_IEEE_VI: b = B_W'(514851);
      CURVE_IEEE_EI: b = B_W'(127612);
      default:       b = '0;
    endcase
    return b;
  endfunction

  // Fractional log2 of a Q30 mantissa in [1,2) by repeated squaring.
  function automatic logic [31:0] lgq(input logic [63:0] v_in);
    logic [63:0] v;
    logic [31:0] r;
    v = v_in;
    r = '0;
    for (int k = 29; k >= 0; k--) begin
      v = (v * v) >> 30;
      if (v >= (Q30_ONE << 1)) begin
        v = v >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  // Largest mantissa whose fractional log2 does not exceed the target, less one.
  function automatic logic [31:0] exp_search(input logic [63:0] tgt);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = Q30_ONE;
    hi = (Q30_ONE << 1) - 64'd1;
    for (int it = 0; it < 32; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if ({32'd0, lgq(mid)} <= tgt) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return 32'(lo - Q30_ONE);
  endfunction

endpackage

// ----- rtl/core/idmt_interp.sv -----
// Four-stage linear interpolation in a constant log2 or exp2 table.
// Depends on idmt_pkg for the table-building functions.
`timescale 1ns / 1ps

module idmt_interp
  import idmt_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = DEF_LOG_TABLE_ENTRIES,
  parameter bit IS_EXP            = 1'b0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] pos,
  output logic [31:0] result
);

  localparam int AW  = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int S_W = 30 + AW;

  logic [31:0] rom [LOG_TABLE_ENTRIES+1];

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] TGT = (64'(g) << 30) / LOG_TABLE_ENTRIES;
    localparam logic [31:0] VAL = (g == LOG_TABLE_ENTRIES) ? 32'(Q30_ONE) :
                                  (IS_EXP ? exp_search(TGT) : lgq(Q30_ONE + TGT));
    assign rom[g] = VAL;
  end

  logic [S_W-1:0] s;
  logic [AW-1:0]  idx_r;
  logic [29:0]    r1_r;
  logic [31:0]    a2_r;
  logic [31:0]    d2_r;
  logic [29:0]    r2_r;
  logic [31:0]    a3_r;
  logic [31:0]    p3_r;
  logic [31:0]    lo_v;
  logic [31:0]    hi_v;
  logic [63:0]    prod;

  assign s    = S_W'(pos) * S_W'(LOG_TABLE_ENTRIES);
  assign lo_v = rom[idx_r];
  assign hi_v = rom[idx_r + AW'(1)];
  assign prod = 64'(d2_r) * 64'(r2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r  <= s[S_W-1:30];
      r1_r   <= s[29:0];
      a2_r   <= lo_v;
      d2_r   <= (hi_v < lo_v) ? 32'd0 : hi_v - lo_v;
      r2_r   <= r1_r;
      a3_r   <= a2_r;
      p3_r   <= prod[61:30];
      result <= a3_r + p3_r;
    end
  end

endmodule

// ----- rtl/core/idmt_div.sv -----
// Pipelined restoring divider: floor(num * 2^sh / den), one quotient bit a stage.
// Depends on idmt_pkg for widths.
`timescale 1ns / 1ps

module idmt_div
  import idmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  input  logic [SH_W-1:0]     sh,
  output logic [QUO_BITS-1:0] quo,
  output logic                sat
);

  logic [REM_W-1:0]    rem_r  [DIV_LAT];
  logic [QUO_BITS-1:0] q_r    [DIV_LAT];
  logic [DEN_W-1:0]    den_r  [DIV_LAT];
  logic                sat_r  [DIV_LAT];
  logic                zero_r [DIV_LAT];
  logic                run_r  [DIV_LAT];

  logic [REM_W-1:0] n_sh;
  logic [REM_W-1:0] den_top;

  assign n_sh    = REM_W'(num) << sh;
  assign den_top = REM_W'(den) << QUO_BITS;

  // The quotient fits 32 bits exactly when the shifted dividend is below den * 2^32.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= n_sh;
      q_r[0]    <= '0;
      den_r[0]  <= den;
      zero_r[0] <= (num == '0);
      sat_r[0]  <= (num != '0) && ((den == '0) || (n_sh >= den_top));
      for (int j = 1; j < DIV_LAT; j++) begin
        if (rem_r[j-1] >= (REM_W'(den_r[j-1]) << (DIV_LAT - 1 - j))) begin
          rem_r[j] <= rem_r[j-1] - (REM_W'(den_r[j-1]) << (DIV_LAT - 1 - j));
          q_r[j]   <= q_r[j-1] | (QUO_BITS'(1) << (DIV_LAT - 1 - j));
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
        den_r[j]  <= den_r[j-1];
        zero_r[j] <= zero_r[j-1];
        sat_r[j]  <= sat_r[j-1];
      end
    end
  end

  // Occupancy marks, used only by the checks below.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_LAT; j++) run_r[j] <= 1'b0;
    end else if (en) begin
      run_r[0] <= 1'b1;
      for (int j = 1; j < DIV_LAT; j++) run_r[j] <= run_r[j-1];
    end
  end

  assign quo = zero_r[DIV_LAT-1] ? '0 :
               sat_r[DIV_LAT-1]  ? '1 : q_r[DIV_LAT-1];
  assign sat = sat_r[DIV_LAT-1];

  a_zero_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    run_r[DIV_LAT-1] && zero_r[DIV_LAT-1] |-> !sat_r[DIV_LAT-1])
    else $error("divider flags both zero dividend and saturation");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    run_r[DIV_LAT-1] && !sat_r[DIV_LAT-1] && den_r[DIV_LAT-1] != '0
      |-> rem_r[DIV_LAT-1] < REM_W'(den_r[DIV_LAT-1]))
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(q_r[DIV_LAT-1]) && $stable(sat_r[DIV_LAT-1]))
    else $error("divider output moved while held");

endmodule

// ----- rtl/core/idmt_trip_time.sv -----
// Top level of the IDMT overcurrent trip-time pipeline.
// Depends on idmt_pkg, idmt_interp and idmt_div.
`timescale 1ns / 1ps

// One request is taken every clock cycle while the output side does not stall, and its
// result passes through one input stage, one coefficient stage, two four-stage table
// interpolations with two stages of log scaling between them, a 33-stage divider that
// loads and then resolves one quotient bit per stage, and then the output register. The
// whole pipeline holds while a finished result waits under stall. The curve constants
// and tables are fixed logic, so no clearing pass follows reset.
module idmt_trip_time
  import idmt_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES  = DEF_LOG_TABLE_ENTRIES,
  parameter int MULTIPLE_FRAC_BITS = DEF_MULTIPLE_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [X_W-1:0]    in_current_multiple,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [T_W-1:0]    out_trip_time,
  output logic              out_no_trip,
  output logic              out_saturated
);

  localparam int F = MULTIPLE_FRAC_BITS;
  localparam logic [X_W:0]   ONE    = (X_W+1)'(1) << F;
  localparam logic [DEN_W:0] ONE_SQ = (DEN_W+1)'(1) << (2 * F);
  localparam logic [SH_W-1:0] SH_LIN = SH_W'(2 * F - 16);
  localparam logic [SH_W-1:0] SH_POW = SH_W'(14);

  logic [CURVE_W-1:0] curve_r;
  logic [TMS_W-1:0]   tms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r <= CURVE_RESET;
      tms_r   <= TMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURVE_SELECT:    curve_r <= cfg_data[CURVE_W-1:0];
        CFG_TIME_MULTIPLIER: tms_r   <= cfg_data[TMS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input stage.
  logic               v1_r;
  logic [X_W-1:0]     x1_r;
  logic [CURVE_W-1:0] c1_r;
  logic [TMS_W-1:0]   t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_current_multiple;
      c1_r <= curve_r;
      t1_r <= tms_r;
    end
  end

  // Coefficient stage: curve class, numerator, simple denominators, log2 split.
  logic [4:0]         msb;
  logic [30:0]        mant;
  logic [2*X_W-1:0]   xx;
  logic [35:0]        bprod;
  side_t              s2;

  always_comb begin
    msb = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x1_r[i]) msb = 5'(i);
    end
  end

  assign mant  = 31'(x1_r) << (5'd30 - msb);
  assign xx    = (2*X_W)'(x1_r) * (2*X_W)'(x1_r);
  assign bprod = 36'(t1_r) * 36'(b_coef(c1_r));

  always_comb begin
    s2.valid   = v1_r;
    s2.no_trip = ((X_W+1)'(x1_r) <= ONE) || (c1_r > CURVE_INST);
    case (c1_r) inside
      CURVE_IEC_SI, CURVE_IEEE_MI:                s2.kind = KIND_POW;
      CURVE_IEC_VI, CURVE_IEC_LTI:                s2.kind = KIND_LIN;
      CURVE_IEC_EI, CURVE_IEEE_VI, CURVE_IEEE_EI: s2.kind = KIND_SQ;
      CURVE_DEFINITE:                             s2.kind = KIND_DEF;
      default:                                    s2.kind = KIND_ZERO;
    endcase
    if (s2.no_trip) s2.kind = KIND_ZERO;
    s2.num    = NUM_W'(t1_r) * NUM_W'(k_coef(c1_r));
    s2.bterm  = bprod[35:16];
    if (s2.kind == KIND_LIN) s2.dsimp = DEN_W'((X_W+1)'(x1_r) - ONE) << F;
    else s2.dsimp = xx - ONE_SQ[DEN_W-1:0];
    s2.sh     = (s2.kind == KIND_POW) ? SH_POW : SH_LIN;
    s2.e      = msb - E_W'(F);
    s2.pos    = mant[29:0];
    s2.defval = DEF_W'(t1_r) << 4;
  end

  side_t side_r [SIDE_LEN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SIDE_LEN; k++) side_r[k].valid <= 1'b0;
    end else if (en) begin
      side_r[0] <= s2;
      for (int k = 1; k <= SIDE_LEN; k++) side_r[k] <= side_r[k-1];
    end
  end

  // log2 M, scaled by 0.02, then exp2 of the result less one.
  logic [31:0] lg_frac;
  logic [31:0] pw_frac;
  logic [35:0] lg_r;
  logic [29:0] y_r;
  logic [62:0] y_full;

  idmt_interp #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES),
    .IS_EXP(1'b0)
  ) u_log (
    .clk(clk),
    .en(en),
    .pos(side_r[0].pos),
    .result(lg_frac)
  );

  assign y_full = 63'(lg_r) * 63'(C_0P02_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      lg_r <= (36'(side_r[INTERP_LAT].e) << 30) + 36'(lg_frac);
      y_r  <= y_full[61:32];
    end
  end

  idmt_interp #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES),
    .IS_EXP(1'b1)
  ) u_exp (
    .clk(clk),
    .en(en),
    .pos(y_r),
    .result(pw_frac)
  );

  // Divider and the tail of the request.
  logic [DEN_W-1:0]    den_sel;
  logic [QUO_BITS-1:0] quo;
  logic                dsat;
  fin_t                fin_r [DIV_LAT];

  assign den_sel = (side_r[SIDE_LEN].kind == KIND_POW) ? DEN_W'(pw_frac)
                                                       : side_r[SIDE_LEN].dsimp;

  idmt_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .num(side_r[SIDE_LEN].num),
    .den(den_sel),
    .sh(side_r[SIDE_LEN].sh),
    .quo(quo),
    .sat(dsat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) fin_r[k].valid <= 1'b0;
    end else if (en) begin
      fin_r[0].valid   <= side_r[SIDE_LEN].valid;
      fin_r[0].kind    <= side_r[SIDE_LEN].kind;
      fin_r[0].no_trip <= side_r[SIDE_LEN].no_trip;
      fin_r[0].bterm   <= side_r[SIDE_LEN].bterm;
      fin_r[0].defval  <= side_r[SIDE_LEN].defval;
      for (int k = 1; k < DIV_LAT; k++) fin_r[k] <= fin_r[k-1];
    end
  end

  fin_t            fl;
  logic [T_W:0]    sum;
  logic [T_W-1:0]  t_nxt;
  logic            sat_nxt;

  assign fl  = fin_r[DIV_LAT-1];
  assign sum = (T_W+1)'(quo) + (T_W+1)'(fl.bterm);

  always_comb begin
    case (fl.kind)
      KIND_ZERO: begin
        t_nxt   = '0;
        sat_nxt = 1'b0;
      end
      KIND_DEF: begin
        t_nxt   = T_W'(fl.defval);
        sat_nxt = 1'b0;
      end
      default: begin
        sat_nxt = dsat || sum[T_W];
        t_nxt   = sat_nxt ? '1 : sum[T_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= fl.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_trip_time <= t_nxt;
      out_no_trip   <= fl.no_trip;
      out_saturated <= sat_nxt;
    end
  end

  a_no_trip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_trip |-> out_trip_time == '0 && !out_saturated)
    else $error("no-trip result carries a delay or saturation");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_trip_time == '1)
    else $error("saturated result not clamped");

  a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(side_r[SIDE_LEN].valid))
    else $error("pipeline advanced while held");

  a_kind_zero_on_no_trip: assert property (@(posedge clk) disable iff (!rst_n)
    side_r[0].valid && side_r[0].no_trip |-> side_r[0].kind == KIND_ZERO)
    else $error("no-trip request classed as a live curve");

endmodule
